/* rtl/max_pool_2d_argmax_assert.svh */
// ============================================================================
// Assertion macros for max_pool_2d_argmax
// Concurrent assertion wrappers on clk with rst_n as disable; empty when
// SYNTHESIS is defined.
// ============================================================================
`ifndef MAX_POOL_2D_ARGMAX_ASSERT_SVH
`define MAX_POOL_2D_ARGMAX_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define MP2A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define MP2A_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MP2A_ASSERT(lbl, prop, msg)
`define MP2A_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/mp2a_pkg.sv */
// ============================================================================
// mp2a_pkg
// Shared constants, register codes and control structs of the max pooling
// block.
// ============================================================================
package mp2a_pkg;

    // Default build sizes.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_POOL_DEF   = 8;
    localparam int DATA_WIDTH_DEF = 16;

    // Register and port widths.
    localparam int POOL_REG_W  = 4;
    localparam int FRAME_REG_W = 9;
    localparam int PLANE_REG_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int POS_W       = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_POOL_HEIGHT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POOL_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_TOTAL  = 3'd5;

    // Register reset values.
    localparam logic [POOL_REG_W-1:0]  POOL_HEIGHT_RST  = 4'd2;
    localparam logic [POOL_REG_W-1:0]  POOL_WIDTH_RST   = 4'd2;
    localparam logic [POOL_REG_W-1:0]  STEP_SIZE_RST    = 4'd2;
    localparam logic [FRAME_REG_W-1:0] FRAME_HEIGHT_RST = 9'd28;
    localparam logic [FRAME_REG_W-1:0] FRAME_WIDTH_RST  = 9'd28;
    localparam logic [PLANE_REG_W-1:0] PLANE_TOTAL_RST  = 16'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the input word, write it, advance counters
        logic read;     // issue one line store read of the window scan
        logic load;     // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;        // the current position closes a window
        logic scan_last;  // the read being issued is the last of the window
        logic out_free;   // the output register can take a result now
    } status_t;

endpackage

/* rtl/mp2a_channels.sv */
// ============================================================================
// mp2a channels
// Valid/ready channel interfaces for input samples and pooled results.
// ============================================================================
interface mp2a_sample_if #(
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mp2a_result_if #(
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [DATA_WIDTH-1:0]        pooled_value;
    logic [mp2a_pkg::POS_W-1:0]   max_position;
    logic                         plane_done;
    logic                         tensor_done;

    modport source (output valid, output pooled_value, output max_position,
                    output plane_done, output tensor_done, input ready);
    modport sink (input valid, input pooled_value, input max_position,
                  input plane_done, input tensor_done, output ready);
endinterface

/* rtl/mp2a_ctrl.sv */
// ============================================================================
// mp2a_ctrl
// Sequencer: takes input words, runs the window scan over the line store and
// hands the result to the output register.
// ============================================================================
`include "max_pool_2d_argmax_assert.svh"

module mp2a_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mp2a_pkg::status_t status,
    output logic              in_ready,
    output mp2a_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.hit)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.read = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last read word is compared in this cycle.
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MP2A_ASSERT(a_hit_starts_scan, cmd.accept && status.hit |=> state_reg == ST_SCAN, "no scan")
    `MP2A_ASSERT(a_drain, state_reg == ST_DRAIN |-> $past(cmd.read && status.scan_last), "early drain")
    `MP2A_ASSERT(a_hold, state_reg == ST_FINISH && !status.out_free |=> $stable(state_reg), "result lost")

endmodule

/* rtl/mp2a_datapath.sv */
// ============================================================================
// mp2a_datapath
// Configuration registers, position counters, circular line store, window
// scan with running maximum, and the output register.
// ============================================================================
`include "max_pool_2d_argmax_assert.svh"

module mp2a_datapath #(
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_POOL   = mp2a_pkg::MAX_POOL_DEF,
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mp2a_pkg::cmd_t                    cmd,
    output mp2a_pkg::status_t                 status,
    input  logic [DATA_WIDTH-1:0]             sample,
    input  logic                              cfg_write,
    input  logic [mp2a_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [DATA_WIDTH-1:0]             pooled_value,
    output logic [mp2a_pkg::POS_W-1:0]        max_position,
    output logic                              plane_done,
    output logic                              tensor_done
);

    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PWW   = $clog2(MAX_POOL + 1);
    localparam int DEPTH = MAX_POOL * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW_RAW = $clog2(MAX_HEIGHT + MAX_WIDTH + 2 * MAX_POOL + 1) + 1;
    localparam int CMPW  = (CMPW_RAW > mp2a_pkg::FRAME_REG_W + 1) ?
                           CMPW_RAW : mp2a_pkg::FRAME_REG_W + 1;
    localparam int PCW   = mp2a_pkg::PLANE_REG_W;
    localparam int POSW  = mp2a_pkg::POS_W;

    // Configuration registers.
    logic [mp2a_pkg::POOL_REG_W-1:0]  pool_height_reg;
    logic [mp2a_pkg::POOL_REG_W-1:0]  pool_width_reg;
    logic [mp2a_pkg::POOL_REG_W-1:0]  step_size_reg;
    logic [mp2a_pkg::FRAME_REG_W-1:0] frame_height_reg;
    logic [mp2a_pkg::FRAME_REG_W-1:0] frame_width_reg;
    logic [PCW-1:0]                   plane_total_reg;
    logic                             cfg_hit;

    // Position state.
    logic [RW-1:0]  row_reg,    row_next;
    logic [CW-1:0]  col_reg,    col_next;
    logic [SW-1:0]  slot_reg,   slot_next;
    logic [SW-1:0]  rphase_reg, rphase_next;
    logic [SW-1:0]  cphase_reg, cphase_next;
    logic [PCW-1:0] plane_reg,  plane_next;

    // Effective sizes.
    logic [HW-1:0]  h_val;
    logic [WW-1:0]  w_val;
    logic [PWW-1:0] ph_raw, pw_raw, ph_val, pw_val, s_val;
    logic [PCW-1:0] total_val;

    // Window scan state.
    logic [SW-1:0]   scan_slot_reg;
    logic [CW-1:0]   scan_col_reg;
    logic [CW-1:0]   col0_reg;
    logic [PWW-1:0]  scan_i_reg;
    logic [PWW-1:0]  scan_j_reg;
    logic [POSW-1:0] scan_pos_reg;
    logic            first_issue_reg;
    logic            pdone_reg;
    logic            tdone_reg;
    logic            rd_valid_reg;
    logic            rd_first_reg;
    logic [POSW-1:0] rd_pos_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] best_reg;
    logic [POSW-1:0]       best_pos_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic [POSW-1:0]       out_pos_reg;
    logic                  pdone_out_reg;
    logic                  tdone_out_reg;

    logic [DATA_WIDTH-1:0] line_store [DEPTH];

    logic            col_pw_ok, row_ph_ok, col_end, row_end, slot_wrap;
    logic            win_hit;
    logic            pdone_now, tdone_now;
    logic [RW-1:0]   r0;
    logic [CW-1:0]   c0;
    logic [SW-1:0]   slot_start;
    logic [POSW-1:0] pos0;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic            row_last_j;
    logic            scan_slot_wrap;

    // Clamp the programmed sizes to what the hardware holds.
    always_comb
    begin
        if (frame_height_reg == '0)
            h_val = HW'(1);
        else if (CMPW'(frame_height_reg) > CMPW'(MAX_HEIGHT))
            h_val = HW'(MAX_HEIGHT);
        else
            h_val = HW'(frame_height_reg);

        if (frame_width_reg == '0)
            w_val = WW'(1);
        else if (CMPW'(frame_width_reg) > CMPW'(MAX_WIDTH))
            w_val = WW'(MAX_WIDTH);
        else
            w_val = WW'(frame_width_reg);

        if (pool_height_reg == '0)
            ph_raw = PWW'(1);
        else if (CMPW'(pool_height_reg) > CMPW'(MAX_POOL))
            ph_raw = PWW'(MAX_POOL);
        else
            ph_raw = PWW'(pool_height_reg);

        if (pool_width_reg == '0)
            pw_raw = PWW'(1);
        else if (CMPW'(pool_width_reg) > CMPW'(MAX_POOL))
            pw_raw = PWW'(MAX_POOL);
        else
            pw_raw = PWW'(pool_width_reg);

        if (step_size_reg == '0)
            s_val = PWW'(1);
        else if (CMPW'(step_size_reg) > CMPW'(MAX_POOL))
            s_val = PWW'(MAX_POOL);
        else
            s_val = PWW'(step_size_reg);

        // A window taller or wider than the frame shrinks to the frame.
        ph_val = (CMPW'(ph_raw) > CMPW'(h_val)) ? PWW'(h_val) : ph_raw;
        pw_val = (CMPW'(pw_raw) > CMPW'(w_val)) ? PWW'(w_val) : pw_raw;

        total_val = (plane_total_reg == '0) ? PCW'(1) : plane_total_reg;
    end

    // Window detection and counter advance for the current position.
    always_comb
    begin
        row_ph_ok = (CMPW'(row_reg) + CMPW'(1)) >= CMPW'(ph_val);
        col_pw_ok = (CMPW'(col_reg) + CMPW'(1)) >= CMPW'(pw_val);
        win_hit = row_ph_ok && col_pw_ok && (rphase_reg == '0) && (cphase_reg == '0);

        // The last window of a row or column is the one with no stride left.
        pdone_now = ((CMPW'(row_reg) + CMPW'(s_val)) >= CMPW'(h_val)) &&
                    ((CMPW'(col_reg) + CMPW'(s_val)) >= CMPW'(w_val));
        tdone_now = pdone_now && ((PCW + 1)'(plane_reg) + (PCW + 1)'(1) >= (PCW + 1)'(total_val));

        r0 = RW'(CMPW'(row_reg) + CMPW'(1) - CMPW'(ph_val));
        c0 = CW'(CMPW'(col_reg) + CMPW'(1) - CMPW'(pw_val));
        if (CMPW'(slot_reg) + CMPW'(1) >= CMPW'(ph_val))
            slot_start = SW'(CMPW'(slot_reg) + CMPW'(1) - CMPW'(ph_val));
        else
            slot_start = SW'(CMPW'(slot_reg) + CMPW'(MAX_POOL) + CMPW'(1) - CMPW'(ph_val));
        pos0 = POSW'(POSW'(r0) * POSW'(w_val)) + POSW'(c0);

        col_end   = (CMPW'(col_reg) + CMPW'(1)) >= CMPW'(w_val);
        row_end   = (CMPW'(row_reg) + CMPW'(1)) >= CMPW'(h_val);
        slot_wrap = (CMPW'(slot_reg) + CMPW'(1)) >= CMPW'(MAX_POOL);

        row_next    = row_reg;
        col_next    = col_reg;
        slot_next   = slot_reg;
        rphase_next = rphase_reg;
        cphase_next = cphase_reg;
        plane_next  = plane_reg;

        if (col_pw_ok)
        begin
            if ((CMPW'(cphase_reg) + CMPW'(1)) >= CMPW'(s_val))
                cphase_next = '0;
            else
                cphase_next = cphase_reg + SW'(1);
        end
        col_next = col_reg + CW'(1);
        if (col_end)
        begin
            col_next    = '0;
            cphase_next = '0;
            if (row_ph_ok)
            begin
                if ((CMPW'(rphase_reg) + CMPW'(1)) >= CMPW'(s_val))
                    rphase_next = '0;
                else
                    rphase_next = rphase_reg + SW'(1);
            end
            row_next  = row_reg + RW'(1);
            slot_next = slot_wrap ? '0 : slot_reg + SW'(1);
            if (row_end)
            begin
                row_next    = '0;
                slot_next   = '0;
                rphase_next = '0;
                if ((PCW + 1)'(plane_reg) + (PCW + 1)'(1) >= (PCW + 1)'(total_val))
                    plane_next = '0;
                else
                    plane_next = plane_reg + PCW'(1);
            end
        end
    end

    always_comb
    begin
        wr_addr = AW'(AW'(slot_reg) * AW'(MAX_WIDTH)) + AW'(col_reg);
        rd_addr = AW'(AW'(scan_slot_reg) * AW'(MAX_WIDTH)) + AW'(scan_col_reg);
        row_last_j = (CMPW'(scan_j_reg) + CMPW'(1)) >= CMPW'(pw_val);
        scan_slot_wrap = (CMPW'(scan_slot_reg) + CMPW'(1)) >= CMPW'(MAX_POOL);
        status.hit = win_hit;
        status.scan_last = row_last_j && ((CMPW'(scan_i_reg) + CMPW'(1)) >= CMPW'(ph_val));
        status.out_free = !out_valid_reg || out_ready;
    end

    assign cfg_hit = cfg_write && (cfg_index == mp2a_pkg::REG_POOL_HEIGHT ||
                                   cfg_index == mp2a_pkg::REG_POOL_WIDTH ||
                                   cfg_index == mp2a_pkg::REG_STEP_SIZE ||
                                   cfg_index == mp2a_pkg::REG_FRAME_HEIGHT ||
                                   cfg_index == mp2a_pkg::REG_FRAME_WIDTH ||
                                   cfg_index == mp2a_pkg::REG_PLANE_TOTAL);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_height_reg  <= mp2a_pkg::POOL_HEIGHT_RST;
            pool_width_reg   <= mp2a_pkg::POOL_WIDTH_RST;
            step_size_reg    <= mp2a_pkg::STEP_SIZE_RST;
            frame_height_reg <= mp2a_pkg::FRAME_HEIGHT_RST;
            frame_width_reg  <= mp2a_pkg::FRAME_WIDTH_RST;
            plane_total_reg  <= mp2a_pkg::PLANE_TOTAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mp2a_pkg::REG_POOL_HEIGHT:
                    pool_height_reg <= cfg_data[mp2a_pkg::POOL_REG_W-1:0];
                mp2a_pkg::REG_POOL_WIDTH:
                    pool_width_reg <= cfg_data[mp2a_pkg::POOL_REG_W-1:0];
                mp2a_pkg::REG_STEP_SIZE:
                    step_size_reg <= cfg_data[mp2a_pkg::POOL_REG_W-1:0];
                mp2a_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[mp2a_pkg::FRAME_REG_W-1:0];
                mp2a_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[mp2a_pkg::FRAME_REG_W-1:0];
                mp2a_pkg::REG_PLANE_TOTAL:
                    plane_total_reg <= cfg_data[PCW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Position counters; any register write restarts the tensor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            slot_reg   <= '0;
            rphase_reg <= '0;
            cphase_reg <= '0;
            plane_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            slot_reg   <= '0;
            rphase_reg <= '0;
            cphase_reg <= '0;
            plane_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            slot_reg   <= slot_next;
            rphase_reg <= rphase_next;
            cphase_reg <= cphase_next;
            plane_reg  <= plane_next;
        end
    end

    // Line store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            line_store[wr_addr] <= sample;
        end
        if (cmd.read)
        begin
            rd_data_reg <= line_store[rd_addr];
        end
    end

    // Scan address walk, row-major over the window.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.hit)
        begin
            scan_slot_reg <= slot_start;
            scan_col_reg  <= c0;
            col0_reg      <= c0;
            scan_i_reg    <= '0;
            scan_j_reg    <= '0;
            scan_pos_reg  <= pos0;
            pdone_reg     <= pdone_now;
            tdone_reg     <= tdone_now;
        end
        else if (cmd.read)
        begin
            if (row_last_j)
            begin
                scan_j_reg    <= '0;
                scan_i_reg    <= scan_i_reg + PWW'(1);
                scan_col_reg  <= col0_reg;
                scan_slot_reg <= scan_slot_wrap ? '0 : scan_slot_reg + SW'(1);
                scan_pos_reg  <= scan_pos_reg + POSW'(w_val) - POSW'(pw_val) + POSW'(1);
            end
            else
            begin
                scan_j_reg   <= scan_j_reg + PWW'(1);
                scan_col_reg <= scan_col_reg + CW'(1);
                scan_pos_reg <= scan_pos_reg + POSW'(1);
            end
        end
        if (cmd.read)
        begin
            rd_pos_reg <= scan_pos_reg;
        end
        // Strict greater-than keeps the earliest position on ties.
        if (rd_valid_reg && (rd_first_reg || $signed(rd_data_reg) > $signed(best_reg)))
        begin
            best_reg     <= rd_data_reg;
            best_pos_reg <= rd_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_issue_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
            rd_first_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.read;
            rd_first_reg <= cmd.read && first_issue_reg;
            if (cmd.accept && status.hit)
                first_issue_reg <= 1'b1;
            else if (cmd.read)
                first_issue_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_value_reg <= best_reg;
            out_pos_reg   <= best_pos_reg;
            pdone_out_reg <= pdone_reg;
            tdone_out_reg <= tdone_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pooled_value = out_value_reg;
    assign max_position = out_pos_reg;
    assign plane_done   = pdone_out_reg;
    assign tensor_done  = tdone_out_reg;

    `MP2A_NEVER(a_tensor_flags, out_valid_reg && tdone_out_reg && !pdone_out_reg, "flag order")
    `MP2A_NEVER(a_load_while_busy, cmd.load && out_valid_reg && !out_ready, "word overwritten")
    `MP2A_NEVER(a_read_on_accept, cmd.accept && cmd.read, "read during accept")

endmodule

/* rtl/max_pool_2d_argmax.sv */
// ============================================================================
// max_pool_2d_argmax
// Streaming 2-D max pooling with the flat position of the first maximum.
// ============================================================================
// Samples arrive in raster order, one plane after another, and are written
// into a circular store of MAX_POOL rows. A sample that does not close a
// stride-aligned window is only written. A sample that closes a window
// starts a scan of that window, one stored entry per cycle through the
// single read port of the line store, followed by a compare step and a load
// of the output register, which waits while the output register is full.
// No sample is taken until that load; the next sample is then taken while
// the result still waits on the output. Any register write restarts the
// position and plane counters.
module max_pool_2d_argmax #(
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_POOL   = mp2a_pkg::MAX_POOL_DEF,
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mp2a_sample_if.sink                      samples,
    mp2a_result_if.source                    results,
    input  logic                             cfg_write,
    input  logic [mp2a_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mp2a_pkg::cmd_t    cmd;
    mp2a_pkg::status_t status;
    logic              in_ready;
    logic              out_valid;
    logic [DATA_WIDTH-1:0]      pooled_value;
    logic [mp2a_pkg::POS_W-1:0] max_position;
    logic              plane_done;
    logic              tensor_done;

    mp2a_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mp2a_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_POOL   (MAX_POOL),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (samples.sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (results.ready),
        .out_valid    (out_valid),
        .pooled_value (pooled_value),
        .max_position (max_position),
        .plane_done   (plane_done),
        .tensor_done  (tensor_done)
    );

    assign samples.ready        = in_ready;
    assign results.valid        = out_valid;
    assign results.pooled_value = pooled_value;
    assign results.max_position = max_position;
    assign results.plane_done   = plane_done;
    assign results.tensor_done  = tensor_done;

endmodule
